// File: src/ctd_pkg.sv
// shared types and constants of the capacitive touch detector
// no dependencies; imported by every module of the block
package ctd_pkg;

  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned LEVEL_W    = 20;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned SUM_W      = LEVEL_W + FRAC_W;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned FILT_SHIFT = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = '1;
  localparam logic [LEVEL_W-1:0] BASELINE_RST = LEVEL_W'(3000);
  localparam logic [CNT_W-1:0]   LIMIT_RST    = CNT_W'(1000);
  localparam logic [STEP_W-1:0]  DROP_RST     = STEP_W'(10);
  localparam logic [STEP_W-1:0]  RISE_RST     = STEP_W'(1);

  typedef enum logic [1:0] {
    REQ_CHARGE    = 2'd0,
    REQ_DISCHARGE = 2'd1,
    REQ_TRACK     = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASELINE_INIT  = 2'd0,
    CFG_DEBOUNCE_LIMIT = 2'd1,
    CFG_DROP_STEP      = 2'd2,
    CFG_RISE_STEP      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                 bl_load;
    logic [LEVEL_W-1:0]   baseline_init;
    logic [CNT_W-1:0]     debounce_limit;
    logic [STEP_W-1:0]    drop_step;
    logic [STEP_W-1:0]    rise_step;
  } cfg_t;

  typedef struct packed {
    logic [TIMER_W-1:0] charge_start;
    logic [SUM_W-1:0]   filt_sum;
    logic [LEVEL_W-1:0] baseline;
    logic [CNT_W-1:0]   count;
    logic               touch;
    logic [TIMER_W-1:0] last_period;
  } pad_state_t;

endpackage

// File: src/capacitive_touch_detector_core.sv
// Capacitive touch detector core: takes one item per cycle when not stalled
// and returns one result per item through an input register, then a result
// register; the pace is set by the per-pad state update, a 29-bit filter
// add/subtract and threshold compare done between the two registers. Every
// pad's state sits in flip-flops and is updated as its item moves into the
// result register, so items for the same pad may follow each other directly.
// A write of baseline_init reloads every pad's baseline at once.
// depends on ctd_pkg, ctd_cfg_regs, ctd_pad_update
module capacitive_touch_detector_core import ctd_pkg::*; #(
  parameter int unsigned NUM_PADS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic                  pad_i,
  input  logic [TIMER_W-1:0]    timer_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  pad_out_o,
  output logic                  touched_o,
  output logic [LEVEL_W-1:0]    filtered_level_o,
  output logic [LEVEL_W-1:0]    baseline_level_o,
  output logic [TIMER_W-1:0]    discharge_period_o,
  output logic [CNT_W-1:0]      debounce_count_o
);

  localparam int unsigned IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam pad_state_t  PAD_RST = '{
    charge_start: '0,
    filt_sum:     '0,
    baseline:     BASELINE_RST,
    count:        '0,
    touch:        1'b0,
    last_period:  '0
  };

  cfg_t               cfg;
  logic               s1_valid_q;
  logic [1:0]         s1_req_q;
  logic               s1_pad_q;
  logic [TIMER_W-1:0] s1_timer_q;
  logic               advance;
  logic               pad_ok;
  logic [IDX_W-1:0]   idx;
  logic               upd_en;
  pad_state_t         st_q [NUM_PADS];
  pad_state_t         cur;
  pad_state_t         nxt;
  logic               out_valid_q;
  logic               out_pad_q;
  pad_state_t         out_q, out_d;

  ctd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q   <= req_type_i;
      s1_pad_q   <= pad_i;
      s1_timer_q <= timer_value_i;
    end
  end

  assign pad_ok = 32'(s1_pad_q) < NUM_PADS;
  assign idx    = IDX_W'(s1_pad_q);
  assign cur    = st_q[idx];
  assign upd_en = advance && pad_ok;

  ctd_pad_update u_upd (
    .req_i   (s1_req_q),
    .timer_i (s1_timer_q),
    .cfg_i   (cfg),
    .cur_i   (cur),
    .nxt_o   (nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PADS; i++) begin
        st_q[i] <= PAD_RST;
      end
    end else if (cfg.bl_load) begin
      for (int i = 0; i < NUM_PADS; i++) begin
        st_q[i].baseline <= cfg.baseline_init;
      end
    end else if (upd_en) begin
      st_q[idx] <= nxt;
    end
  end

  assign out_d = pad_ok ? nxt : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pad_q <= s1_pad_q;
      out_q     <= out_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pad_out_o          = out_pad_q;
  assign touched_o          = out_q.touch;
  assign filtered_level_o   = out_q.filt_sum[SUM_W-1:FRAC_W];
  assign baseline_level_o   = out_q.baseline;
  assign discharge_period_o = out_q.last_period;
  assign debounce_count_o   = out_q.count;

  // a stalled input side means the result side is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && s1_valid_q && !out_ready_i))
    else $error("input stalled while result register has room");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("moved item did not reach result register");

  a_bl_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.bl_load |=> (st_q[0].baseline == $past(cfg_data_i[LEVEL_W-1:0])))
    else $error("baseline reload not applied");

  a_touch_on_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(st_q[0].touch) |->
      $past(upd_en && idx == '0 && req_e'(s1_req_q) == REQ_DISCHARGE))
    else $error("touch flag changed outside a discharge edge");

endmodule

// File: src/ctd_cfg_regs.sv
// configuration registers of the capacitive touch detector
// depends on ctd_pkg
module ctd_cfg_regs import ctd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic               wr;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [STEP_W-1:0]  drop_q, drop_d;
  logic [STEP_W-1:0]  rise_q, rise_d;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  always_comb begin
    limit_d   = limit_q;
    drop_d    = drop_q;
    rise_d    = rise_q;
    if (wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        // baseline init only reloads the pad baselines
        CFG_BASELINE_INIT:  ;
        CFG_DEBOUNCE_LIMIT: limit_d   = cfg_data_i[CNT_W-1:0];
        CFG_DROP_STEP:      drop_d    = cfg_data_i[STEP_W-1:0];
        CFG_RISE_STEP:      rise_d    = cfg_data_i[STEP_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RST;
      drop_q    <= DROP_RST;
      rise_q    <= RISE_RST;
    end else begin
      limit_q   <= limit_d;
      drop_q    <= drop_d;
      rise_q    <= rise_d;
    end
  end

  assign cfg_o.bl_load        = wr && (cfg_reg_e'(cfg_index_i) == CFG_BASELINE_INIT);
  assign cfg_o.baseline_init  = cfg_data_i[LEVEL_W-1:0];
  assign cfg_o.debounce_limit = limit_q;
  assign cfg_o.drop_step      = drop_q;
  assign cfg_o.rise_step      = rise_q;

endmodule

// File: src/ctd_pad_update.sv
// next-state logic for one pad: period, leaky filter, debounce, baseline track
// depends on ctd_pkg
module ctd_pad_update import ctd_pkg::*; (
  input  logic [1:0]         req_i,
  input  logic [TIMER_W-1:0] timer_i,
  input  cfg_t               cfg_i,
  input  pad_state_t         cur_i,
  output pad_state_t         nxt_o
);

  logic [TIMER_W-1:0] period;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_new;
  logic [SUM_W:0]     thr;
  logic               ge;
  logic [CNT_W-1:0]   cnt_new;
  logic [SUM_W-1:0]   bl_fix;
  logic [LEVEL_W:0]   bl_rise;
  logic [LEVEL_W-1:0] bl_new;

  // wrap case drops one tick
  assign period = timer_i - cur_i.charge_start
                  - TIMER_W'(timer_i < cur_i.charge_start);

  assign sum_ext = (SUM_W+1)'(cur_i.filt_sum) + (SUM_W+1)'({period, FRAC_W'(0)})
                   - (SUM_W+1)'(cur_i.filt_sum >> FILT_SHIFT);
  assign sum_new = sum_ext[SUM_W-1:0];

  assign thr = {cur_i.baseline, 1'b0, FRAC_W'(0)};
  assign ge  = (SUM_W+1)'(sum_new) >= thr;

  always_comb begin
    cnt_new = cur_i.count;
    if (ge && !cur_i.touch) begin
      if (cur_i.count != CNT_MAX) cnt_new = cur_i.count + CNT_W'(1);
    end else if (!ge && cur_i.count != '0) begin
      cnt_new = cur_i.count - CNT_W'(1);
    end
  end

  assign bl_fix  = {cur_i.baseline, FRAC_W'(0)};
  assign bl_rise = (LEVEL_W+1)'(cur_i.baseline) + (LEVEL_W+1)'(cfg_i.rise_step);

  always_comb begin
    bl_new = cur_i.baseline;
    if (bl_fix > cur_i.filt_sum) begin
      bl_new = (cur_i.baseline > LEVEL_W'(cfg_i.drop_step))
               ? cur_i.baseline - LEVEL_W'(cfg_i.drop_step) : '0;
    end else if (bl_fix < cur_i.filt_sum) begin
      bl_new = bl_rise[LEVEL_W] ? LEVEL_MAX : bl_rise[LEVEL_W-1:0];
    end
  end

  always_comb begin
    nxt_o = cur_i;
    unique case (req_e'(req_i))
      REQ_CHARGE: nxt_o.charge_start = timer_i;
      REQ_DISCHARGE: begin
        nxt_o.last_period = period;
        nxt_o.filt_sum    = sum_new;
        nxt_o.count       = cnt_new;
        nxt_o.touch       = cnt_new >= cfg_i.debounce_limit;
      end
      REQ_TRACK: begin
        if (!cur_i.touch) nxt_o.baseline = bl_new;
      end
      default: ;
    endcase
  end

endmodule
